// ----- rtl/core/tvw_pkg.sv -----
`timescale 1ns / 1ps

package tvw_pkg;

  localparam int STACK_DEPTH     = 64;
  localparam int SINE_TABLE_SIZE = 256;

  localparam int SYM_W   = 8;
  localparam int POS_W   = 32;
  localparam int BOX_W   = 31;
  localparam int PIX_W   = 24;
  localparam int HEAD_W  = 16;
  localparam int CFG_W   = 16;
  localparam int TRIG_W  = 17;
  localparam int FRAC_W  = 14;
  localparam int IDX_W   = $clog2(SINE_TABLE_SIZE + 1);
  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int PADDR_W = 3;

  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_OPEN  = 8'h5B;
  localparam logic [SYM_W-1:0] SYM_CLOSE = 8'h5D;

  localparam logic REG_STEP_LENGTH = 1'b0;
  localparam logic REG_TURN_ANGLE  = 1'b1;

  localparam logic [CFG_W-1:0] STEP_LENGTH_RESET = 16'd256;
  localparam logic [CFG_W-1:0] TURN_ANGLE_RESET  = 16'd4096;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [1:6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

  typedef enum logic [2:0] {
    ACT_TURN      = 3'd0,
    ACT_LINE      = 3'd1,
    ACT_MOVE      = 3'd2,
    ACT_PUSH_DROP = 3'd3,
    ACT_POP_DROP  = 3'd4
  } action_e;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [HEAD_W-1:0]       h;
  } pose_t;

  typedef struct packed {
    logic [CFG_W-1:0] step_length;
    logic [CFG_W-1:0] turn_angle;
  } cfg_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sine;
    logic signed [TRIG_W-1:0] cosine;
  } trig_t;

  typedef struct packed {
    action_e                 action;
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic signed [POS_W-1:0] min_x;
    logic [BOX_W-1:0]        max_x;
    logic signed [POS_W-1:0] min_y;
    logic [BOX_W-1:0]        max_y;
  } res_t;

  typedef logic [15:0] wave_t [SINE_TABLE_SIZE+1];

  // Quarter-wave sine table in Q1.15, built from a truncated Taylor series.
  function automatic wave_t build_wave();
    wave_t              w;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [63:0] s;
    for (int k = 0; k <= SINE_TABLE_SIZE; k++) begin
      x  = (64'(k) * HALF_PI_Q30) / 64'(SINE_TABLE_SIZE);
      x2 = (x * x) >> 30;
      t  = x;
      s  = $signed(x);
      for (int n = 1; n <= 6; n++) begin
        t = ((t * x2) >> 30) / TAYLOR_DIV[n];
        if (n % 2 == 1) begin
          s = s - $signed(t);
        end else begin
          s = s + $signed(t);
        end
      end
      if (s < 0) begin
        s = 0;
      end
      s = (s + 64'sd16384) >>> 15;
      if (s > 64'sd32768) begin
        s = 64'sd32768;
      end
      w[k] = 16'(s);
    end
    return w;
  endfunction

  localparam wave_t WAVE = build_wave();

endpackage

// ----- rtl/core/tvw_ram.sv -----
`timescale 1ns / 1ps

module tvw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/tvw_regs.sv -----
`timescale 1ns / 1ps

module tvw_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tvw_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output tvw_pkg::cfg_t               cfg_o
);
  import tvw_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;
  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_STEP_LENGTH: cfg_d.step_length = pwdata[CFG_W-1:0];
        REG_TURN_ANGLE:  cfg_d.turn_angle  = pwdata[CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_STEP_LENGTH: prdata = 32'(cfg_q.step_length);
      REG_TURN_ANGLE:  prdata = 32'(cfg_q.turn_angle);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_length <= STEP_LENGTH_RESET;
      cfg_q.turn_angle  <= TURN_ANGLE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/tvw_trig.sv -----
`timescale 1ns / 1ps

module tvw_trig (
  input  logic [tvw_pkg::HEAD_W-1:0] heading_i,
  output tvw_pkg::trig_t             trig_o
);
  import tvw_pkg::*;

  localparam int SCALE_W = FRAC_W + IDX_W;

  logic [SCALE_W-1:0]      scaled;
  logic [IDX_W-1:0]        idx_i;
  logic [IDX_W-1:0]        idx_j;
  logic signed [TRIG_W-1:0] t_i;
  logic signed [TRIG_W-1:0] t_j;

  assign scaled = SCALE_W'(heading_i[FRAC_W-1:0]) * SCALE_W'(SINE_TABLE_SIZE);
  assign idx_i  = IDX_W'(scaled >> FRAC_W);
  assign idx_j  = IDX_W'(SINE_TABLE_SIZE) - idx_i;
  assign t_i    = $signed({1'b0, WAVE[idx_i]});
  assign t_j    = $signed({1'b0, WAVE[idx_j]});

  // The cosine is the sine one quadrant ahead, so both share the two lookups.
  always_comb begin
    case (heading_i[HEAD_W-1:HEAD_W-2])
      2'd0: begin
        trig_o.sine   = t_i;
        trig_o.cosine = t_j;
      end
      2'd1: begin
        trig_o.sine   = t_j;
        trig_o.cosine = -t_i;
      end
      2'd2: begin
        trig_o.sine   = -t_i;
        trig_o.cosine = -t_j;
      end
      default: begin
        trig_o.sine   = -t_j;
        trig_o.cosine = t_i;
      end
    endcase
  end

endmodule

// ----- rtl/core/tvw_out_buf.sv -----
`timescale 1ns / 1ps

module tvw_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tvw_pkg::res_t res_i,
  output logic          room_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tvw_pkg::res_t res_o
);
  import tvw_pkg::*;

  logic out_valid_q;
  logic out_valid_d;
  logic skid_valid_q;
  logic skid_valid_d;
  logic out_load;
  logic skid_load;
  logic out_take;
  res_t out_q;
  res_t skid_q;

  assign out_take = out_valid_q && out_ready_i;
  assign room_o   = !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_load     = 1'b0;
    skid_load    = 1'b0;
    if (skid_valid_q) begin
      if (out_take) begin
        out_load     = 1'b1;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || out_take) begin
        out_load    = 1'b1;
        out_valid_d = 1'b1;
      end else begin
        skid_load    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= skid_valid_q ? skid_q : res_i;
    end
    if (skid_load) begin
      skid_q <= res_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

// ----- rtl/core/turtle_vector_walker_top.sv -----
`timescale 1ns / 1ps
// A symbol's result is registered into the result buffer when the symbol is accepted.
// One symbol per cycle while in_ready_o is high; pose, stack and box update on acceptance.
// A two-entry result buffer keeps input transfers going while one result is stalled.
// Reset clears pose, heading, stack depth, box and buffer; registers return to defaults.
// The pose stack RAM needs no clearing pass.
module turtle_vector_walker_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  symbol_i,
  input  logic                        restart_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  action_o,
  output logic signed [23:0]          pixel_x_o,
  output logic signed [23:0]          pixel_y_o,
  output logic signed [31:0]          box_min_x_o,
  output logic [30:0]                 box_max_x_o,
  output logic signed [31:0]          box_min_y_o,
  output logic [30:0]                 box_max_y_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tvw_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import tvw_pkg::*;

  function automatic logic signed [POS_W-1:0] advance(logic signed [POS_W-1:0] p,
                                                     logic [CFG_W-1:0] len,
                                                     logic signed [TRIG_W-1:0] trig);
    logic signed [33:0]      prod;
    logic signed [18:0]      delta;
    logic signed [POS_W:0]   sum;
    prod  = 34'($signed({1'b0, len})) * 34'(trig);
    prod  = prod + 34'sd16384;
    delta = 19'(prod >>> 15);
    sum   = (POS_W+1)'(p) + (POS_W+1)'(delta);
    if (sum[POS_W] != sum[POS_W-1]) begin
      return sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end
    return sum[POS_W-1:0];
  endfunction

  // Rounds up, or toward zero when round_up is low, and saturates to the pixel range.
  function automatic logic signed [PIX_W-1:0] to_pixel(logic signed [POS_W-1:0] p,
                                                      logic round_up);
    logic signed [POS_W:0]   sum;
    logic signed [PIX_W:0]   pix;
    sum = (POS_W+1)'(p) + ((round_up || p[POS_W-1]) ? 33'sd255 : 33'sd0);
    pix = sum[POS_W:8];
    if (pix[PIX_W] != pix[PIX_W-1]) begin
      return pix[PIX_W] ? {1'b1, {(PIX_W-1){1'b0}}} : {1'b0, {(PIX_W-1){1'b1}}};
    end
    return pix[PIX_W-1:0];
  endfunction

  cfg_t                    cfg;
  trig_t                   trig;
  res_t                    res;
  res_t                    res_out;
  logic                    room;
  logic                    fire;

  pose_t                   pose_q;
  pose_t                   pose_d;
  pose_t                   pose_cur;
  pose_t                   top_q;
  pose_t                   top_d;
  pose_t                   below;
  logic [DEPTH_W-1:0]      depth_q;
  logic [DEPTH_W-1:0]      depth_d;
  logic [DEPTH_W-1:0]      depth_cur;
  logic [DEPTH_W-1:0]      rd_ptr;
  logic signed [POS_W-1:0] min_x_q;
  logic signed [POS_W-1:0] min_x_d;
  logic signed [POS_W-1:0] min_x_cur;
  logic signed [POS_W-1:0] min_y_q;
  logic signed [POS_W-1:0] min_y_d;
  logic signed [POS_W-1:0] min_y_cur;
  logic [BOX_W-1:0]        max_x_q;
  logic [BOX_W-1:0]        max_x_d;
  logic [BOX_W-1:0]        max_x_cur;
  logic [BOX_W-1:0]        max_y_q;
  logic [BOX_W-1:0]        max_y_d;
  logic [BOX_W-1:0]        max_y_cur;
  logic signed [POS_W-1:0] step_x;
  logic signed [POS_W-1:0] step_y;
  logic                    push_we;

  tvw_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign fire       = in_valid_i && room;
  assign in_ready_o = room;

  assign pose_cur  = restart_i ? '0 : pose_q;
  assign depth_cur = restart_i ? '0 : depth_q;
  assign min_x_cur = restart_i ? '0 : min_x_q;
  assign min_y_cur = restart_i ? '0 : min_y_q;
  assign max_x_cur = restart_i ? '0 : max_x_q;
  assign max_y_cur = restart_i ? '0 : max_y_q;

  tvw_trig u_trig (
    .heading_i (pose_cur.h),
    .trig_o    (trig)
  );

  assign step_x = advance(pose_cur.x, cfg.step_length, trig.cosine);
  assign step_y = advance(pose_cur.y, cfg.step_length, trig.sine);

  always_comb begin
    pose_d      = pose_cur;
    top_d       = top_q;
    depth_d     = depth_cur;
    min_x_d     = min_x_cur;
    min_y_d     = min_y_cur;
    max_x_d     = max_x_cur;
    max_y_d     = max_y_cur;
    push_we     = 1'b0;
    res.action  = ACT_TURN;
    res.pixel_x = '0;
    res.pixel_y = '0;
    unique case (symbol_i)
      SYM_PLUS:  pose_d.h = pose_cur.h - cfg.turn_angle;
      SYM_MINUS: pose_d.h = pose_cur.h + cfg.turn_angle;
      SYM_OPEN: begin
        if (depth_cur < DEPTH_W'(STACK_DEPTH)) begin
          push_we = 1'b1;
          top_d   = pose_cur;
          depth_d = depth_cur + DEPTH_W'(1);
        end else begin
          res.action = ACT_PUSH_DROP;
        end
      end
      SYM_CLOSE: begin
        if (depth_cur != '0) begin
          pose_d      = top_q;
          top_d       = below;
          depth_d     = depth_cur - DEPTH_W'(1);
          res.action  = ACT_MOVE;
          res.pixel_x = to_pixel(top_q.x, 1'b0);
          res.pixel_y = to_pixel(top_q.y, 1'b0);
        end else begin
          res.action = ACT_POP_DROP;
        end
      end
      default: begin
        pose_d.x = step_x;
        pose_d.y = step_y;
        if (step_x > $signed({1'b0, max_x_cur})) begin
          max_x_d = step_x[BOX_W-1:0];
        end
        if (step_x < min_x_cur) begin
          min_x_d = step_x;
        end
        if (step_y > $signed({1'b0, max_y_cur})) begin
          max_y_d = step_y[BOX_W-1:0];
        end
        if (step_y < min_y_cur) begin
          min_y_d = step_y;
        end
        res.action  = ACT_LINE;
        res.pixel_x = to_pixel(step_x, 1'b1);
        res.pixel_y = to_pixel(step_y, 1'b1);
      end
    endcase
    res.min_x = min_x_d;
    res.max_x = max_x_d;
    res.min_y = min_y_d;
    res.max_y = max_y_d;
  end

  // The top entry lives in top_q; the RAM read port always presents the entry below it.
  assign rd_ptr = (fire ? depth_d : depth_q) - DEPTH_W'(2);

  tvw_ram #(
    .WIDTH ($bits(pose_t)),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (fire && push_we),
    .waddr_i (depth_cur[ADDR_W-1:0]),
    .wdata_i (pose_cur),
    .raddr_i (rd_ptr[ADDR_W-1:0]),
    .rdata_o (below)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_q  <= '0;
      depth_q <= '0;
      min_x_q <= '0;
      min_y_q <= '0;
      max_x_q <= '0;
      max_y_q <= '0;
    end else if (fire) begin
      pose_q  <= pose_d;
      depth_q <= depth_d;
      min_x_q <= min_x_d;
      min_y_q <= min_y_d;
      max_x_q <= max_x_d;
      max_y_q <= max_y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      top_q <= top_d;
    end
  end

  tvw_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .res_i       (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign action_o    = res_out.action;
  assign pixel_x_o   = res_out.pixel_x;
  assign pixel_y_o   = res_out.pixel_y;
  assign box_min_x_o = res_out.min_x;
  assign box_max_x_o = res_out.max_x;
  assign box_min_y_o = res_out.min_y;
  assign box_max_y_o = res_out.max_y;

endmodule

// ----- rtl/core/tvw_checker.sv -----
`timescale 1ns / 1ps

module tvw_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic [7:0]                  symbol_i,
  input logic                        restart_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [2:0]                  action_o,
  input logic signed [23:0]          pixel_x_o,
  input logic signed [23:0]          pixel_y_o,
  input logic signed [31:0]          box_min_x_o,
  input logic [30:0]                 box_max_x_o,
  input logic signed [31:0]          box_min_y_o,
  input logic [30:0]                 box_max_y_o
);
  import tvw_pkg::*;

  logic in_xfer;

  assign in_xfer = in_valid_i && in_ready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable({action_o, pixel_x_o, pixel_y_o, box_min_x_o, box_max_x_o,
               box_min_y_o, box_max_y_o}))
    else $error("Stalled result changed or vanished.");

  a_result_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !out_valid_o |=> out_valid_o)
    else $error("Accepted symbol produced no result in the next cycle.");

  a_full_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("Input stalled while no result is pending.");

  a_restart_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && restart_i && symbol_i == SYM_PLUS && !out_valid_o |=>
      action_o == ACT_TURN && pixel_x_o == '0 && pixel_y_o == '0 &&
      box_min_x_o == '0 && box_max_x_o == '0 && box_min_y_o == '0 && box_max_y_o == '0)
    else $error("Turn after restart did not report a cleared box.");

  a_restart_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && restart_i && symbol_i == SYM_CLOSE && !out_valid_o |=>
      action_o == ACT_POP_DROP)
    else $error("Pop after restart was not dropped.");

endmodule

bind turtle_vector_walker_top tvw_checker u_tvw_checker (.*);

// ----- dv/tb_turtle_vector_walker_top.sv -----
`timescale 1ns / 1ps

module tb_turtle_vector_walker_top;
  import tvw_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 10;
  localparam int DIAGONAL_STEPS = 24;

  typedef struct packed {
    logic       restart;
    logic [7:0] symbol;
  } walk_cmd_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [7:0]          symbol_i = '0;
  logic                restart_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [2:0]          action_o;
  logic signed [23:0]  pixel_x_o;
  logic signed [23:0]  pixel_y_o;
  logic signed [31:0]  box_min_x_o;
  logic [30:0]         box_max_x_o;
  logic signed [31:0]  box_min_y_o;
  logic [30:0]         box_max_y_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  walk_cmd_t symbol_queue [$];
  res_t      predicted_results [$];
  walk_cmd_t next_cmd;
  int        queued_in_phase;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        mismatches = 0;
  int        cycles = 0;

  // Predictor state: pose, stack and box, plus the configuration it walks with.
  logic [15:0]       cfg_step = STEP_LENGTH_RESET;
  logic [15:0]       cfg_turn = TURN_ANGLE_RESET;
  logic signed [31:0] cur_x, cur_y, lo_x, hi_x, lo_y, hi_y;
  logic [15:0]       cur_head;
  int                stack_cnt;
  pose_t             pose_mem [STACK_DEPTH];
  int                quarter_sine [0:SINE_TABLE_SIZE];

  turtle_vector_walker_top dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic void fill_quarter_sine();
    logic [63:0]        ang;
    logic [63:0]        ang_sq;
    logic [63:0]        term;
    logic signed [63:0] acc;
    for (int k = 0; k <= SINE_TABLE_SIZE; k++) begin
      ang = (64'(k) * HALF_PI_Q30) / 64'(SINE_TABLE_SIZE);
      ang_sq = (ang * ang) >> 30;
      term = ang;
      acc = $signed(ang);
      for (int n = 1; n <= 6; n++) begin
        term = ((term * ang_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
        acc = (n % 2 == 1) ? acc - $signed(term) : acc + $signed(term);
      end
      if (acc < 0) acc = 0;
      acc = (acc + 64'sd16384) >>> 15;
      if (acc > 64'sd32768) acc = 64'sd32768;
      quarter_sine[k] = int'(acc);
    end
  endfunction

  function automatic int sine_at(input logic [15:0] h);
    int i;
    i = (int'(h[13:0]) * SINE_TABLE_SIZE) >> 14;
    case (h[15:14])
      2'd0: return quarter_sine[i];
      2'd1: return quarter_sine[SINE_TABLE_SIZE - i];
      2'd2: return -quarter_sine[i];
      default: return -quarter_sine[SINE_TABLE_SIZE - i];
    endcase
  endfunction

  function automatic logic signed [31:0] step_axis(input logic signed [31:0] p, input int trig);
    longint d;
    longint r;
    d = (longint'({1'b0, cfg_step}) * trig + 16384) >>> 15;
    r = longint'(p) + d;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return 32'(r);
  endfunction

  function automatic logic signed [23:0] pixel_clamp(input longint v);
    if (v > 64'sd8388607) return 24'sd8388607;
    if (v < -64'sd8388608) return -24'sd8388608;
    return 24'(v);
  endfunction

  function automatic res_t walk_symbol(input logic [7:0] sym, input logic clear);
    res_t r;
    r = '0;
    r.action = ACT_TURN;
    if (clear) begin
      cur_x = 0;
      cur_y = 0;
      cur_head = 0;
      stack_cnt = 0;
      lo_x = 0;
      hi_x = 0;
      lo_y = 0;
      hi_y = 0;
    end
    if (sym == SYM_PLUS) begin
      cur_head = cur_head - cfg_turn;
    end else if (sym == SYM_MINUS) begin
      cur_head = cur_head + cfg_turn;
    end else if (sym == SYM_OPEN) begin
      if (stack_cnt < STACK_DEPTH) begin
        pose_mem[stack_cnt] = '{x: cur_x, y: cur_y, h: cur_head};
        stack_cnt++;
      end else begin
        r.action = ACT_PUSH_DROP;
      end
    end else if (sym == SYM_CLOSE) begin
      if (stack_cnt > 0) begin
        stack_cnt--;
        cur_x = pose_mem[stack_cnt].x;
        cur_y = pose_mem[stack_cnt].y;
        cur_head = pose_mem[stack_cnt].h;
        r.action = ACT_MOVE;
        r.pixel_x = pixel_clamp(cur_x >= 0 ? longint'(cur_x) >>> 8
                                           : -((-longint'(cur_x)) >>> 8));
        r.pixel_y = pixel_clamp(cur_y >= 0 ? longint'(cur_y) >>> 8
                                           : -((-longint'(cur_y)) >>> 8));
      end else begin
        r.action = ACT_POP_DROP;
      end
    end else begin
      cur_x = step_axis(cur_x, sine_at(cur_head + 16'h4000));
      cur_y = step_axis(cur_y, sine_at(cur_head));
      if (cur_x > hi_x) hi_x = cur_x;
      if (cur_x < lo_x) lo_x = cur_x;
      if (cur_y > hi_y) hi_y = cur_y;
      if (cur_y < lo_y) lo_y = cur_y;
      r.action = ACT_LINE;
      r.pixel_x = pixel_clamp((longint'(cur_x) + 255) >>> 8);
      r.pixel_y = pixel_clamp((longint'(cur_y) + 255) >>> 8);
    end
    r.min_x = lo_x;
    r.max_x = hi_x[30:0];
    r.min_y = lo_y;
    r.max_y = hi_y[30:0];
    return r;
  endfunction

  task automatic check_field(input string field, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  function automatic logic [7:0] draw_symbol();
    logic [7:0] s;
    s = 8'($urandom_range(0, 255));
    if (s == SYM_PLUS || s == SYM_MINUS || s == SYM_OPEN || s == SYM_CLOSE) s = 8'h46;
    return s;
  endfunction

  function automatic logic [7:0] command_symbol();
    case ($urandom_range(0, 3))
      0: return SYM_PLUS;
      1: return SYM_MINUS;
      2: return SYM_OPEN;
      default: return SYM_CLOSE;
    endcase
  endfunction

  task automatic queue_cmd(input logic [7:0] sym, input logic clear);
    symbol_queue.push_back('{restart: clear, symbol: sym});
    queued_in_phase++;
  endtask

  task automatic add_sequence();
    int         kind;
    int         len;
    int         open;
    int         pick;
    logic       clear_first;
    logic [7:0] s;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      len = $urandom_range(8, 30);
      open = 0;
      clear_first = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          s = draw_symbol();
        end else if (pick < 65) begin
          s = $urandom_range(0, 1) ? SYM_PLUS : SYM_MINUS;
        end else if (pick < 82) begin
          s = SYM_OPEN;
          open++;
        end else if (open > 0) begin
          s = SYM_CLOSE;
          open--;
        end else begin
          s = draw_symbol();
        end
        queue_cmd(s, clear_first && k == 0);
      end
      while (open > 0) begin
        queue_cmd(SYM_CLOSE, 1'b0);
        open--;
      end
    end else if (kind < 65) begin
      len = $urandom_range(62, 70);
      queue_cmd(SYM_OPEN, 1'b1);
      for (int k = 1; k < len; k++) begin
        queue_cmd(SYM_OPEN, 1'b0);
        if ($urandom_range(0, 2) == 0) queue_cmd(draw_symbol(), 1'b0);
        if ($urandom_range(0, 4) == 0) queue_cmd(SYM_MINUS, 1'b0);
      end
      len = len + $urandom_range(0, 3);
      for (int k = 0; k < len; k++) begin
        queue_cmd(SYM_CLOSE, 1'b0);
        if ($urandom_range(0, 3) == 0) queue_cmd(draw_symbol(), 1'b0);
      end
    end else begin
      len = $urandom_range(5, 20);
      for (int k = 0; k < len; k++) begin
        s = $urandom_range(0, 1) ? command_symbol() : 8'($urandom_range(0, 255));
        queue_cmd(s, $urandom_range(0, 15) == 0);
      end
    end
  endtask

  task automatic wait_drained();
    while (symbol_queue.size() != 0 || in_valid_i || predicted_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic write_cfg_reg(input logic idx, input logic [15:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= {16'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_STEP_LENGTH) begin
      cfg_step = value;
    end else begin
      cfg_turn = value;
    end
  endtask

  task automatic run_phase(input logic [15:0] step, input logic [15:0] turn,
                           input int send_pct, input int recv_pct, input int count);
    wait_drained();
    write_cfg_reg(REG_STEP_LENGTH, step);
    write_cfg_reg(REG_TURN_ANGLE, turn);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    queued_in_phase = 0;
    while (queued_in_phase < count / 2) add_sequence();
    // The sender holds off here until every outstanding result has come back.
    wait_drained();
    while (queued_in_phase < count) add_sequence();
  endtask

  task automatic diagonal_walk(input int turns);
    queue_cmd(SYM_MINUS, 1'b1);
    repeat (turns - 1) queue_cmd(SYM_MINUS, 1'b0);
    repeat (DIAGONAL_STEPS) queue_cmd(draw_symbol(), 1'b0);
    queue_cmd(SYM_OPEN, 1'b0);
    queue_cmd(SYM_CLOSE, 1'b0);
    queue_cmd(draw_symbol(), 1'b0);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predicted_results.push_back(walk_symbol(symbol_i, restart_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (symbol_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_cmd = symbol_queue.pop_front();
          in_valid_i <= 1'b1;
          symbol_i <= next_cmd.symbol;
          restart_i <= next_cmd.restart;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin : result_monitor
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (predicted_results.size() == 0) begin
        $error("result transfer with no symbol outstanding");
        mismatches++;
      end else begin
        want = predicted_results.pop_front();
        check_field("action", want.action, action_o);
        check_field("pixel_x", want.pixel_x, pixel_x_o);
        check_field("pixel_y", want.pixel_y, pixel_y_o);
        check_field("box_min_x", want.min_x, box_min_x_o);
        check_field("box_max_x", want.max_x, box_max_x_o);
        check_field("box_min_y", want.min_y, box_min_y_o);
        check_field("box_max_y", want.max_y, box_max_y_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    walk_cmd_t directed [$];
    fill_quarter_sine();
    void'(walk_symbol(8'h2B, 1'b1));
    cur_head = 0;
    send_idle_pct = 34;
    recv_idle_pct = 56;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    directed = '{'{1'b0, SYM_CLOSE}, '{1'b0, 8'h00}, '{1'b0, SYM_PLUS},
                 '{1'b0, 8'hFF}, '{1'b0, SYM_OPEN}, '{1'b0, SYM_MINUS},
                 '{1'b0, SYM_MINUS}, '{1'b0, 8'h46}, '{1'b0, SYM_CLOSE},
                 '{1'b0, SYM_CLOSE}, '{1'b0, SYM_PLUS}, '{1'b0, SYM_PLUS},
                 '{1'b0, SYM_PLUS}, '{1'b0, SYM_PLUS}, '{1'b0, 8'h41},
                 '{1'b0, SYM_OPEN}, '{1'b0, 8'h80}, '{1'b0, SYM_CLOSE},
                 '{1'b0, SYM_OPEN}, '{1'b1, SYM_CLOSE}, '{1'b1, 8'h7F},
                 '{1'b1, SYM_MINUS}, '{1'b0, 8'h01}};
    foreach (directed[k]) queue_cmd(directed[k].symbol, directed[k].restart);

    run_phase(16'hFFFF, 16'hFFFF, 34, 56, 180);
    run_phase(16'd0, 16'd0, 34, 56, 180);
    run_phase(16'd256, 16'h4000, 56, 34, 180);
    run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 56, 34, 180);
    run_phase(16'd1, 16'h2000, 0, 0, 180);
    run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 0, 0, 200);

    // Short straight walks at full step give the largest moves on both axes.
    wait_drained();
    write_cfg_reg(REG_STEP_LENGTH, 16'hFFFF);
    write_cfg_reg(REG_TURN_ANGLE, 16'h2000);
    diagonal_walk(1);
    diagonal_walk(5);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
